// ----- hdl/aca_pkg.sv -----
// ---------------------------------------------------------------------------
// aca_pkg
// Shared types and constants for the double-array trie multi-pattern scanner.
// ---------------------------------------------------------------------------
package aca_pkg;

    // operation codes of an input beat
    localparam logic [1:0] OP_NODE_WR = 2'd0;
    localparam logic [1:0] OP_LIST_WR = 2'd1;
    localparam logic [1:0] OP_START   = 2'd2;
    localparam logic [1:0] OP_SCAN    = 2'd3;

    // match_mode register codes
    localparam logic [1:0] MODE_FULL    = 2'd0;
    localparam logic [1:0] MODE_SEGMENT = 2'd1;
    localparam logic [1:0] MODE_PREFIX  = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    // root node index
    localparam int unsigned ROOT_NODE = 255;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] entry_address;
        logic [15:0] base_value;
        logic [15:0] check_value;
        logic [15:0] fail_value;
        logic [15:0] list_head_value;
        logic [19:0] pattern_value;
        logic [15:0] list_next_value;
        logic [7:0]  text_byte;
    } in_item_t;

    typedef struct packed {
        logic        match_valid;
        logic [19:0] pattern_index;
        logic [31:0] end_position;
        logic        halted;
        logic        overflow;
        logic        last;
    } out_item_t;

    // one node table entry
    typedef struct packed {
        logic [15:0] base;
        logic [15:0] check;
        logic [15:0] fail;
        logic [15:0] list;
    } node_ent_t;

    // table port controls from the sequencer
    typedef struct packed {
        logic node_re;
        logic node_we;
        logic list_re;
        logic list_we;
    } tbl_ctrl_t;

endpackage

// ----- hdl/aho_corasick_double_array_scan.sv -----
// ---------------------------------------------------------------------------
// aho_corasick_double_array_scan
// Multi-pattern byte scanner over a double-array trie with fail links.
// ---------------------------------------------------------------------------
// After reset the node table is swept to zero, one entry a cycle, and s_ready
// stays low until the sweep is done; configuration writes are taken meanwhile.
// A scanned byte is worked through by one sequencer over the single read port
// of each table: fall-back steps, match-list entries reported and fail-chain
// nodes visited each add to its time; the block takes no new beat until the
// last result of the byte is in the output register.
// Each scanned byte gives at least one result beat; the last one is marked.
// ---------------------------------------------------------------------------
module aho_corasick_double_array_scan import aca_pkg::*; #(
    parameter int NODE_ADDR_BITS = 16,
    parameter int LIST_ADDR_BITS = 16,
    parameter int PATTERN_BITS   = 20,
    parameter int MAX_RUN        = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_data
);

    localparam int NB = NODE_ADDR_BITS;
    localparam int LB = LIST_ADDR_BITS;
    localparam int CB = $clog2(MAX_RUN + 1);
    localparam logic [NB-1:0] ROOT = NB'(ROOT_NODE);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDC   = 4'd1;
    localparam logic [3:0] S_RDN   = 4'd2;
    localparam logic [3:0] S_EV    = 4'd3;
    localparam logic [3:0] S_WN    = 4'd4;
    localparam logic [3:0] S_LRD   = 4'd5;
    localparam logic [3:0] S_LUSE  = 4'd6;
    localparam logic [3:0] S_NEXTN = 4'd7;
    localparam logic [3:0] S_NLAT  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_HALT  = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        mode_reg, mode_next;
    logic [NB-1:0]     cur_reg, cur_next;
    logic [NB-1:0]     walk_reg, walk_next;
    logic [31:0]       offset_reg, offset_next;
    logic              stopped_reg, stopped_next;
    logic [7:0]        byte_reg, byte_next;
    logic [15:0]       fail_reg, fail_next;
    node_ent_t         ent_reg, ent_next;
    logic [NB:0]       steps_reg, steps_next;
    logic [LB-1:0]     e_reg, e_next;
    logic [CB-1:0]     count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic              pend_v_reg, pend_v_next;
    logic [19:0]       pend_reg, pend_next;
    logic              out_v_reg, out_v_next;
    out_item_t         out_reg, out_next;

    tbl_ctrl_t               ctrl;
    logic [NB-1:0]           node_raddr;
    node_ent_t               node_q;
    logic [PATTERN_BITS-1:0] list_qpat;
    logic [15:0]             list_qnext;
    logic                    clear_busy;
    node_ent_t               node_wdata;
    logic [PATTERN_BITS-1:0] list_wpat;

    logic [1:0]    eff_mode;
    logic          prefix;
    logic          out_free;
    logic          s_fire;
    logic [NB-1:0] child;
    logic [NB-1:0] fail_cur;
    logic [NB-1:0] fail_walk;
    logic [NB-1:0] fb_node;
    logic [NB:0]   steps_inc;
    logic          chk_ok;
    logic [19:0]   qpat20;

    aca_tables #(
        .NODE_ADDR_BITS (NODE_ADDR_BITS),
        .LIST_ADDR_BITS (LIST_ADDR_BITS),
        .PATTERN_BITS   (PATTERN_BITS)
    ) u_tables (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .node_raddr (node_raddr),
        .node_waddr (NB'(32'(s_data.entry_address))),
        .node_wdata (node_wdata),
        .node_q     (node_q),
        .list_raddr (e_reg),
        .list_waddr (LB'(32'(s_data.entry_address))),
        .list_wpat  (list_wpat),
        .list_wnext (s_data.list_next_value),
        .list_qpat  (list_qpat),
        .list_qnext (list_qnext),
        .clear_busy (clear_busy)
    );

    assign node_wdata = '{base:  s_data.base_value,  check: s_data.check_value,
                          fail:  s_data.fail_value,  list:  s_data.list_head_value};
    assign list_wpat  = PATTERN_BITS'(64'(s_data.pattern_value));
    assign qpat20     = 20'(64'(list_qpat));

    assign s_ready   = (state_reg == S_IDLE) && !clear_busy;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_v_reg;
    assign m_data    = out_reg;
    assign out_free  = !out_v_reg || m_ready;

    // unused mode 3 behaves as full matching
    assign eff_mode  = (mode_reg == MODE_UNUSED) ? MODE_FULL : mode_reg;
    assign prefix    = (eff_mode == MODE_PREFIX);

    // address arithmetic, wrapped to table width
    assign child     = NB'(32'(node_q.base) + 32'(byte_reg));
    assign fail_cur  = NB'(32'(fail_reg));
    assign fail_walk = NB'(32'(ent_reg.fail));
    assign steps_inc = steps_reg + 1'b1;
    assign fb_node   = steps_inc[NB] ? ROOT : fail_cur;
    assign chk_ok    = (32'(node_q.check) == 32'(cur_reg));

    // sequencer
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        cur_next     = cur_reg;
        walk_next    = walk_reg;
        offset_next  = offset_reg;
        stopped_next = stopped_reg;
        byte_next    = byte_reg;
        fail_next    = fail_reg;
        ent_next     = ent_reg;
        steps_next   = steps_reg;
        e_next       = e_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        pend_v_next  = pend_v_reg;
        pend_next    = pend_reg;
        out_v_next   = out_v_reg && !m_ready;
        out_next     = out_reg;
        ctrl         = '0;
        node_raddr   = cur_reg;

        if (cfg_valid) begin
            mode_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    byte_next = s_data.text_byte;
                    case (s_data.operation)
                        OP_NODE_WR: ctrl.node_we = 1'b1;
                        OP_LIST_WR: ctrl.list_we = 1'b1;
                        OP_START: begin
                            cur_next     = ROOT;
                            offset_next  = '0;
                            stopped_next = 1'b0;
                        end
                        default: begin
                            state_next = stopped_reg ? S_HALT : S_RDC;
                            steps_next = '0;
                        end
                    endcase
                end
            end
            // read the current node
            S_RDC: begin
                ctrl.node_re = 1'b1;
                node_raddr   = cur_reg;
                state_next   = S_RDN;
            end
            // read its child on this byte
            S_RDN: begin
                fail_next    = node_q.fail;
                ctrl.node_re = 1'b1;
                node_raddr   = child;
                walk_next    = child;
                state_next   = S_EV;
            end
            // check the parent, fall back, halt or commit
            S_EV: begin
                if (prefix && !chk_ok) begin
                    stopped_next = 1'b1;
                    state_next   = S_HALT;
                end else if (!prefix && cur_reg != ROOT && !chk_ok) begin
                    steps_next = steps_inc;
                    if (eff_mode == MODE_SEGMENT && fb_node == ROOT) begin
                        cur_next     = ROOT;
                        stopped_next = 1'b1;
                        state_next   = S_HALT;
                    end else begin
                        cur_next   = fb_node;
                        state_next = S_RDC;
                    end
                end else begin
                    if (chk_ok) begin
                        cur_next  = walk_reg;
                    end else begin
                        walk_next = cur_reg;
                    end
                    ent_next     = node_q;
                    offset_next  = offset_reg + 1'b1;
                    steps_next   = '0;
                    count_next   = '0;
                    dropped_next = 1'b0;
                    pend_v_next  = 1'b0;
                    state_next   = S_WN;
                end
            end
            // visit one node of the report walk
            S_WN: begin
                if (!prefix && (walk_reg == ROOT || steps_reg[NB])) begin
                    state_next = S_FIN;
                end else begin
                    e_next     = LB'(32'(ent_reg.list));
                    state_next = (LB'(32'(ent_reg.list)) == '0) ? S_NEXTN : S_LRD;
                end
            end
            S_LRD: begin
                ctrl.list_re = 1'b1;
                state_next   = S_LUSE;
            end
            // one list entry: push into the pending slot, or stop at the cap
            S_LUSE: begin
                if (32'(count_reg) >= 32'(MAX_RUN)) begin
                    dropped_next = 1'b1;
                    state_next   = S_FIN;
                end else if (!pend_v_reg || out_free) begin
                    if (pend_v_reg) begin
                        out_v_next = 1'b1;
                        out_next   = '{match_valid: 1'b1, pattern_index: pend_reg,
                                       end_position: offset_reg, halted: 1'b0,
                                       overflow: 1'b0, last: 1'b0};
                    end
                    pend_v_next = 1'b1;
                    pend_next   = qpat20;
                    count_next  = count_reg + 1'b1;
                    e_next      = LB'(32'(list_qnext));
                    state_next  = (LB'(32'(list_qnext)) == '0) ? S_NEXTN : S_LRD;
                end
            end
            // follow the fail link, or finish in prefix mode
            S_NEXTN: begin
                if (prefix) begin
                    state_next = S_FIN;
                end else begin
                    walk_next    = fail_walk;
                    steps_next   = steps_inc;
                    ctrl.node_re = 1'b1;
                    node_raddr   = fail_walk;
                    state_next   = S_NLAT;
                end
            end
            S_NLAT: begin
                ent_next   = node_q;
                state_next = S_WN;
            end
            // final result of the byte
            S_FIN: begin
                if (out_free) begin
                    out_v_next  = 1'b1;
                    out_next    = '{match_valid: pend_v_reg,
                                    pattern_index: pend_v_reg ? pend_reg : 20'd0,
                                    end_position: offset_reg, halted: 1'b0,
                                    overflow: dropped_reg, last: 1'b1};
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            S_HALT: begin
                if (out_free) begin
                    out_v_next = 1'b1;
                    out_next   = '{match_valid: 1'b0, pattern_index: 20'd0,
                                   end_position: offset_reg, halted: 1'b1,
                                   overflow: 1'b0, last: 1'b1};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= MODE_FULL;
            cur_reg     <= ROOT;
            offset_reg  <= '0;
            stopped_reg <= 1'b0;
            pend_v_reg  <= 1'b0;
            out_v_reg   <= 1'b0;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            steps_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            cur_reg     <= cur_next;
            offset_reg  <= offset_next;
            stopped_reg <= stopped_next;
            pend_v_reg  <= pend_v_next;
            out_v_reg   <= out_v_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            steps_reg   <= steps_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        walk_reg <= walk_next;
        byte_reg <= byte_next;
        fail_reg <= fail_next;
        ent_reg  <= ent_next;
        e_reg    <= e_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // no match left pending between bytes
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !pend_v_reg)
        else $error("pending match left after byte finished");

    // match count never exceeds the cap
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(MAX_RUN))
        else $error("match count beyond cap");

    // a halted result carries no match and closes the byte
    a_halt_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && out_reg.halted |-> !out_reg.match_valid && out_reg.last)
        else $error("malformed halted result");

    // no beat taken during the clearing sweep
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !s_ready)
        else $error("input taken while clearing");

endmodule

// ----- hdl/aca_tables.sv -----
// ---------------------------------------------------------------------------
// aca_tables
// Node table and match-list table, one write and one registered read port
// each. The node table is swept to zero after reset.
// ---------------------------------------------------------------------------
module aca_tables import aca_pkg::*; #(
    parameter int NODE_ADDR_BITS = 16,
    parameter int LIST_ADDR_BITS = 16,
    parameter int PATTERN_BITS   = 20
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tbl_ctrl_t                 ctrl,
    input  logic [NODE_ADDR_BITS-1:0] node_raddr,
    input  logic [NODE_ADDR_BITS-1:0] node_waddr,
    input  node_ent_t                 node_wdata,
    output node_ent_t                 node_q,
    input  logic [LIST_ADDR_BITS-1:0] list_raddr,
    input  logic [LIST_ADDR_BITS-1:0] list_waddr,
    input  logic [PATTERN_BITS-1:0]   list_wpat,
    input  logic [15:0]               list_wnext,
    output logic [PATTERN_BITS-1:0]   list_qpat,
    output logic [15:0]               list_qnext,
    output logic                      clear_busy
);

    localparam int NODE_DEPTH = 1 << NODE_ADDR_BITS;
    localparam int LIST_DEPTH = 1 << LIST_ADDR_BITS;

    node_ent_t                   node_mem [NODE_DEPTH];
    logic [PATTERN_BITS-1:0]     pat_mem  [LIST_DEPTH];
    logic [15:0]                 next_mem [LIST_DEPTH];

    logic [NODE_ADDR_BITS-1:0]   clr_reg, clr_next;
    logic                        busy_reg, busy_next;

    // clearing sweep, one entry a cycle
    always_comb begin
        clr_next  = clr_reg;
        busy_next = busy_reg;
        if (busy_reg) begin
            clr_next = clr_reg + 1'b1;
            if (&clr_reg) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end else begin
            clr_reg  <= clr_next;
            busy_reg <= busy_next;
        end
    end

    assign clear_busy = busy_reg;

    // node table
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            node_mem[clr_reg] <= '0;
        end else if (ctrl.node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (ctrl.node_re) begin
            node_q <= node_mem[node_raddr];
        end
    end

    // match-list table
    always_ff @(posedge aclk) begin
        if (ctrl.list_we) begin
            pat_mem[list_waddr]  <= list_wpat;
            next_mem[list_waddr] <= list_wnext;
        end
        if (ctrl.list_re) begin
            list_qpat  <= pat_mem[list_raddr];
            list_qnext <= next_mem[list_raddr];
        end
    end

endmodule
